>>> rtl/bbt_pkg.sv
// Package for the Bollinger band tracker.
// Holds the shared constants, the sequencer state type and default parameter values.
// No dependencies.
package bbt_pkg;

    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 8;

    localparam int CFG_W         = 7;
    localparam int WIN_LEN_RESET = 20;
    localparam int MIN_WINDOW    = 2;
    localparam int BAND_K        = 2;
    localparam int DIV_STEP      = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_SUB,
        ST_NQ_LO,
        ST_NQ_HI,
        ST_SS,
        ST_VAR,
        ST_START,
        ST_ROOT,
        ST_SIGMA,
        ST_DONE
    } t_state;

endpackage

>>> rtl/bollinger_band_tracker.sv
// Top level of the Bollinger band tracker: sequencer, shared multiplier and running sums.
// Uses bbt_pkg, bbt_ring, bbt_isqrt and bbt_divider.
//
// Each price sample accepted on the slave stream yields one transaction on the master
// stream carrying the window mean and the mean plus and minus two standard deviations in
// fixed point, with tuser high once the window is full. The block works on one sample at
// a time and drops tready until that sample's result is in the output register. A sample
// taken while the window is still filling only updates the ring and the running sums; a
// full window also runs the one-bit-per-cycle square root loop beside the mean division,
// then the four-bit-per-cycle divider on the root to give the standard deviation.
// A stalled output register keeps tready low until it can take the new result. Writing
// the window length clears the window, and tuser high on an input sample clears it
// before that sample is taken.
module bollinger_band_tracker
    import bbt_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    localparam int MID_W  = SAMPLE_BITS + FRAC_BITS,
    localparam int BAND_W = MID_W + 1,
    localparam int IN_DW  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_DW = ((MID_W + 2 * BAND_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // price_sample
    input  logic              s_axis_tuser,   // series_start
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // middle_band, upper_band, lower_band
    output logic              m_axis_tuser    // bands_valid
);

    localparam int AW      = $clog2(MAX_WINDOW);
    localparam int NB      = $clog2(MAX_WINDOW + 1);
    localparam int PW      = NB + 1;
    localparam int SUM_W   = SAMPLE_BITS + AW;
    localparam int Q_W     = 2 * SAMPLE_BITS + AW;
    localparam int VAR_W   = Q_W + NB;
    localparam int R_W     = (VAR_W + 2 * FRAC_BITS + 1) / 2;
    localparam int DIV_RAW = (SUM_W + FRAC_BITS > R_W) ? SUM_W + FRAC_BITS : R_W;
    localparam int DIV_W   = ((DIV_RAW + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]       r_win_len;
    logic [NB-1:0]          r_fill;
    logic [AW-1:0]          r_slot;
    logic [SUM_W-1:0]       r_sum;
    logic [Q_W-1:0]         r_sq_sum;
    logic [SAMPLE_BITS-1:0] r_x;
    logic                   r_drop;
    logic                   r_full;
    logic [2*SUM_W-1:0]     r_prod;
    logic [VAR_W-1:0]       r_acc;
    logic [MID_W-1:0]       r_mean;

    logic                   r_out_valid;
    logic                   r_out_flag;
    logic [MID_W-1:0]       r_out_mid;
    logic [BAND_W-1:0]      r_out_up;
    logic [BAND_W-1:0]      r_out_low;

    logic [NB-1:0]          win_n;
    logic [AW-1:0]          old_slot;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   ring_rd_en;
    logic                   ring_wr_en;
    logic [SUM_W-1:0]       mul_a;
    logic [SUM_W-1:0]       mul_b;
    logic [2*SUM_W-1:0]     mul_p;
    logic                   sqrt_start;
    logic                   sqrt_busy;
    logic [R_W-1:0]         sqrt_root;
    logic                   div_start;
    logic                   div_busy;
    logic [DIV_W-1:0]       div_dividend;
    logic [DIV_W-1:0]       div_quot;
    logic                   in_acc;
    logic                   out_load;
    logic [MID_W-1:0]       sigma;
    logic [BAND_W-1:0]      span;

    always_comb begin
        logic [31:0] len32;
        len32 = 32'(r_win_len);
        if (len32 < 32'(MIN_WINDOW)) begin
            win_n = NB'(MIN_WINDOW);
        end else if (len32 > 32'(MAX_WINDOW)) begin
            win_n = NB'(MAX_WINDOW);
        end else begin
            win_n = NB'(len32);
        end
    end

    always_comb begin
        logic [PW-1:0] s_ext;
        logic [PW-1:0] n_ext;
        logic [PW-1:0] o_ext;
        s_ext = PW'(r_slot);
        n_ext = PW'(win_n);
        if (s_ext >= n_ext) begin
            o_ext = s_ext - n_ext;
        end else begin
            o_ext = s_ext + PW'(MAX_WINDOW) - n_ext;
        end
        old_slot = AW'(o_ext);
    end

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign mul_p    = mul_a * mul_b;
    assign sigma    = MID_W'(div_quot);
    assign span     = BAND_W'(sigma) * BAND_W'(BAND_K);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        ring_rd_en   = 1'b0;
        ring_wr_en   = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(sqrt_root);
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                ring_rd_en = 1'b1;
                mul_a      = SUM_W'(r_x);
                mul_b      = SUM_W'(r_x);
                n_state    = ST_ADD;
            end
            ST_ADD: begin
                ring_wr_en = 1'b1;
                mul_a      = SUM_W'(rd_data);
                mul_b      = SUM_W'(rd_data);
                n_state    = ST_SUB;
            end
            ST_SUB: begin
                n_state = (r_fill >= win_n) ? ST_NQ_LO : ST_DONE;
            end
            ST_NQ_LO: begin
                mul_a   = SUM_W'(win_n);
                mul_b   = r_sq_sum[SUM_W-1:0];
                n_state = ST_NQ_HI;
            end
            ST_NQ_HI: begin
                mul_a   = SUM_W'(win_n);
                mul_b   = SUM_W'(r_sq_sum[Q_W-1:SUM_W]);
                n_state = ST_SS;
            end
            ST_SS: begin
                mul_a   = r_sum;
                mul_b   = r_sum;
                n_state = ST_VAR;
            end
            ST_VAR: begin
                n_state = ST_START;
            end
            ST_START: begin
                sqrt_start   = 1'b1;
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_sum) << FRAC_BITS;
                n_state      = ST_ROOT;
            end
            ST_ROOT: begin
                if (!sqrt_busy && !div_busy) begin
                    div_start = 1'b1;
                    n_state   = ST_SIGMA;
                end
            end
            ST_SIGMA: begin
                if (!div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= CFG_W'(WIN_LEN_RESET);
            r_fill    <= '0;
            r_slot    <= '0;
            r_sum     <= '0;
            r_sq_sum  <= '0;
        end else if (i_cfg_wr_en) begin
            r_win_len <= i_cfg_wr_data;
            r_fill    <= '0;
            r_slot    <= '0;
            r_sum     <= '0;
            r_sq_sum  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && s_axis_tuser) begin
                        r_fill   <= '0;
                        r_slot   <= '0;
                        r_sum    <= '0;
                        r_sq_sum <= '0;
                    end
                end
                ST_ADD: begin
                    r_sum    <= r_sum + SUM_W'(r_x);
                    r_sq_sum <= r_sq_sum + Q_W'(r_prod);
                    r_slot   <= (r_slot == AW'(MAX_WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    if (r_fill < win_n) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                ST_SUB: begin
                    if (r_drop) begin
                        r_sum    <= r_sum - SUM_W'(rd_data);
                        r_sq_sum <= r_sq_sum - Q_W'(r_prod);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_x <= s_axis_tdata[SAMPLE_BITS-1:0];
                end
            end
            ST_READ: begin
                r_drop <= (r_fill >= win_n);
            end
            ST_SUB: begin
                r_full <= (r_fill >= win_n);
            end
            ST_NQ_HI: begin
                r_acc <= VAR_W'(r_prod);
            end
            ST_SS: begin
                r_acc <= r_acc + VAR_W'({r_prod, SUM_W'(0)});
            end
            ST_VAR: begin
                r_acc <= r_acc - VAR_W'(r_prod);
            end
            ST_ROOT: begin
                if (!sqrt_busy && !div_busy) begin
                    r_mean <= MID_W'(div_quot);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_flag <= r_full;
            if (r_full) begin
                r_out_mid <= r_mean;
                r_out_up  <= BAND_W'(r_mean) + span;
                r_out_low <= BAND_W'(r_mean) - span;
            end else begin
                r_out_mid <= '0;
                r_out_up  <= '0;
                r_out_low <= '0;
            end
        end
    end

    bbt_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ring_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_x),
        .i_rd_en   (ring_rd_en),
        .i_rd_addr (old_slot),
        .o_rd_data (rd_data)
    );

    bbt_isqrt #(
        .R_W (R_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value ((2*R_W)'(r_acc) << (2 * FRAC_BITS)),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    bbt_divider #(
        .DIV_W (DIV_W),
        .NB    (NB)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (win_n),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_flag;
    assign m_axis_tdata  = OUT_DW'({r_out_low, r_out_up, r_out_mid});

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Input accepted twice in a row.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= win_n)
        else $error("Fill count exceeds the window length.");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= AW'(MAX_WINDOW - 1))
        else $error("Write slot outside the ring.");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!sqrt_busy && !div_busy))
        else $error("Arithmetic unit busy while the sequencer is idle.");

endmodule

>>> rtl/bbt_ring.sv
// Sample ring memory for the Bollinger band tracker.
// One write port and one read port with registered read data; no dependencies.
module bbt_ring #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bbt_isqrt.sv
// Iterative integer square root for the Bollinger band tracker.
// Produces one root bit per cycle; no dependencies.
module bbt_isqrt #(
    parameter int R_W = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2*R_W-1:0] i_value,
    output logic             o_busy,
    output logic [R_W-1:0]   o_root
);

    localparam int CNT_W = $clog2(R_W + 1);

    logic [2*R_W-1:0] r_v;
    logic [R_W:0]     r_rem;
    logic [R_W-1:0]   r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [R_W+2:0] rem_sh;
    logic [R_W+2:0] trial;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_v[2*R_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(R_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v    <= r_v << 2;
            r_root <= {r_root[R_W-2:0], ge};
            if (ge) begin
                r_rem <= (R_W+1)'(rem_sh - trial);
            end else begin
                r_rem <= (R_W+1)'(rem_sh);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

>>> rtl/bbt_divider.sv
// Shared iterative divider for the Bollinger band tracker.
// Retires DIV_STEP quotient bits per cycle against a narrow divisor; uses bbt_pkg.
module bbt_divider
    import bbt_pkg::*;
#(
    parameter int DIV_W = 32,
    parameter int NB    = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [NB-1:0]    i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quot
);

    localparam int DIV_CYC = DIV_W / DIV_STEP;
    localparam int CNT_W   = $clog2(DIV_CYC + 1);

    logic [DIV_W-1:0] r_q;
    logic [NB-1:0]    r_rem;
    logic [NB-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DIV_W-1:0] q_nx;
    logic [NB-1:0]    rem_nx;

    always_comb begin
        logic [NB:0] rem2;
        logic        ge;
        q_nx   = r_q;
        rem_nx = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            rem2 = {rem_nx, q_nx[DIV_W-1]};
            ge   = (rem2 >= {1'b0, r_div});
            if (ge) begin
                rem_nx = NB'(rem2 - {1'b0, r_div});
            end else begin
                rem_nx = NB'(rem2);
            end
            q_nx = {q_nx[DIV_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_CYC);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= q_nx;
            r_rem <= rem_nx;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

>>> tb/bbt_band_checker.sv
// Scoreboard for the Bollinger band tracker: watches the config port and both streams.
// Predicts mean and bands per sample and compares each output transaction field by field.
// Depends on bbt_pkg.
`timescale 1ns / 100ps
module bbt_band_checker
    import bbt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // price_sample
    input  logic        s_axis_tuser,   // series_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // middle_band, upper_band, lower_band
    input  logic        m_axis_tuser,   // bands_valid
    output int          o_mismatch_count,
    output int          o_outstanding,
    output int          o_result_count,
    output int          o_full_count
);

    typedef struct packed {
        logic        valid;
        logic [23:0] middle;
        logic [24:0] upper;
        logic [24:0] lower;
    } t_band_set;

    logic [CFG_W-1:0] win_len;
    logic [15:0]      ring [0:DEF_MAX_WINDOW-1];
    logic [5:0]       write_slot;
    logic [6:0]       fill_count;
    logic [21:0]      run_sum;
    logic [37:0]      run_sq_sum;

    t_band_set expected_bands[$];
    int        mismatch_count;
    int        result_count;
    int        full_count;

    function automatic void clear_window();
        write_slot = '0;
        fill_count = '0;
        run_sum    = '0;
        run_sq_sum = '0;
    endfunction

    function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
        bit [63:0] root;
        bit [63:0] probe;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > v) probe >>= 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Takes one sample into the window and returns the bands it produces.
    function automatic t_band_set take_sample(input logic [15:0] price, input logic restart);
        int unsigned n;
        logic [5:0]  old_slot;
        logic [15:0] old;
        bit [63:0]   s, q, nq, ss, var_nn, mean, sigma, span;
        t_band_set   r;
        n = win_len;
        if (n < MIN_WINDOW) n = MIN_WINDOW;
        if (n > DEF_MAX_WINDOW) n = DEF_MAX_WINDOW;
        if (restart) clear_window();
        if (fill_count >= n) begin
            old_slot   = 6'((write_slot + DEF_MAX_WINDOW - n) % DEF_MAX_WINDOW);
            old        = ring[old_slot];
            run_sum    = run_sum - 22'(old);
            run_sq_sum = run_sq_sum - 38'(old) * 38'(old);
        end
        ring[write_slot] = price;
        run_sum    = run_sum + 22'(price);
        run_sq_sum = run_sq_sum + 38'(price) * 38'(price);
        write_slot = write_slot + 6'd1;
        if (fill_count < n) fill_count = fill_count + 7'd1;
        r = '0;
        if (fill_count >= n) begin
            s      = 64'(run_sum);
            q      = 64'(run_sq_sum);
            nq     = 64'(n) * q;
            ss     = s * s;
            var_nn = (nq >= ss) ? nq - ss : 64'd0;
            mean   = (s << DEF_FRAC_BITS) / 64'(n);
            sigma  = floor_sqrt(var_nn << (2 * DEF_FRAC_BITS)) / 64'(n);
            span   = 64'(BAND_K) * sigma;
            r.valid  = 1'b1;
            r.middle = mean[23:0];
            r.upper  = 25'(mean + span);
            r.lower  = 25'(mean - span);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("bbt_band_checker: mismatch on result %0d: %s", result_count, what);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_band_set want;
        if (expected_bands.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, tdata %h", m_axis_tdata));
            return;
        end
        want = expected_bands.pop_front();
        if (m_axis_tuser !== want.valid)
            report_mismatch($sformatf("bands_valid %b, want %b", m_axis_tuser, want.valid));
        if (m_axis_tdata[23:0] !== want.middle)
            report_mismatch($sformatf("middle_band %h, want %h", m_axis_tdata[23:0],
                want.middle));
        if (m_axis_tdata[48:24] !== want.upper)
            report_mismatch($sformatf("upper_band %h, want %h", m_axis_tdata[48:24],
                want.upper));
        if (m_axis_tdata[73:49] !== want.lower)
            report_mismatch($sformatf("lower_band %h, want %h", m_axis_tdata[73:49],
                want.lower));
        result_count++;
        if (want.valid) full_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_len = CFG_W'(WIN_LEN_RESET);
            clear_window();
            expected_bands.delete();
        end else begin
            if (i_cfg_wr_en) begin
                win_len = i_cfg_wr_data;
                clear_window();
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_bands.insert(expected_bands.size(),
                    take_sample(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
        o_mismatch_count <= mismatch_count;
        o_outstanding    <= expected_bands.size();
        o_result_count   <= result_count;
        o_full_count     <= full_count;
    end

endmodule

>>> tb/tb_top.sv
// Top of the Bollinger band tracker testbench: clock, reset, stimulus and verdict.
// Instantiates bollinger_band_tracker and bbt_band_checker; uses bbt_pkg.
`timescale 1ns / 100ps
module tb_top;
    import bbt_pkg::*;

    localparam int RANDOM_ITEMS   = 1850;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 80;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [15:0]      s_axis_tdata = '0;
    logic             s_axis_tuser = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [79:0]      m_axis_tdata;
    logic             m_axis_tuser;

    int mismatches;
    int outstanding;
    int results_seen;
    int full_results;
    int sent_count = 0;
    int cfg_writes = 0;

    always #10 i_clk = ~i_clk;

    bollinger_band_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bbt_band_checker u_band_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tuser     (m_axis_tuser),
        .o_mismatch_count (mismatches),
        .o_outstanding    (outstanding),
        .o_result_count   (results_seen),
        .o_full_count     (full_results)
    );

    task automatic send_sample(input logic [15:0] price, input logic restart);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= price;
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic pause_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // The window length is only changed once every result has drained.
    task automatic write_window(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (2) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int          setting;
        int          window_val;
        int          eff;
        int          phase_items;
        int          price_mode;
        int          base;
        int          burst_left;
        int          gap;
        int          random_sent;
        logic [15:0] price;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, first at the reset window length, then at short windows, clamped ones included.
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd12345, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        write_window(7'd0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'd40000, 1'b1);
        send_sample(16'd1, 1'b0);
        send_sample(16'h8000, 1'b0);
        write_window(7'd1);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        write_window(7'd3);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);

        setting     = 0;
        random_sent = 0;
        burst_left  = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (setting % 8)
                0: window_val = 2;
                1: window_val = 64;
                2: window_val = 127;
                3: window_val = 5;
                4: window_val = 65;
                5: window_val = 0;
                6: window_val = 1;
                default: window_val = $urandom_range(0, 127);
            endcase
            eff = window_val;
            if (eff < MIN_WINDOW) eff = MIN_WINDOW;
            if (eff > DEF_MAX_WINDOW) eff = DEF_MAX_WINDOW;
            write_window(CFG_W'(window_val));
            phase_items = eff + $urandom_range(20, 3 * eff + 20);
            price_mode  = $urandom_range(0, 4);
            base        = $urandom_range(0, 65532);
            repeat (phase_items) begin
                if (random_sent >= RANDOM_ITEMS) break;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    if (gap > 0) pause_sender(gap);
                end
                burst_left--;
                case (price_mode)
                    1: price = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    2: price = 16'(base + $urandom_range(0, 3));
                    3: price = 16'($urandom_range(0, 255));
                    default: price = 16'($urandom_range(0, 65535));
                endcase
                send_sample(price, $urandom_range(0, 59) == 0);
                random_sent++;
            end
            setting++;
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d samples over %0d window length writes, %0d results checked",
            sent_count, cfg_writes, results_seen);
        $display("tb_top: %0d results had full bands; series restarts and a long stall included",
            full_results);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Output side: stall patterns of varying density, plus one long hold-off under load.
    initial begin
        int seg;
        int mode;
        bit held;
        held = 1'b0;
        forever begin
            if (!held && sent_count >= 400) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 120);
            repeat (seg) begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 4) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("tb_top: timeout with %0d results outstanding", outstanding);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
rtl/bbt_pkg.sv
rtl/bbt_ring.sv
rtl/bbt_isqrt.sv
rtl/bbt_divider.sv
rtl/bollinger_band_tracker.sv
tb/bbt_band_checker.sv
tb/tb_top.sv
